@@ src/phtr_pkg.sv @@
// Shared types and constants for the prefix height table range finder.
// No dependencies; imported by the controller, datapath and top level.
`timescale 1ns / 1ps
package phtr_pkg;

   localparam int MAX_ENTRIES = 1024;
   localparam int HEIGHT_BITS = 16;
   localparam int ADDR_W      = $clog2(MAX_ENTRIES);
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
   localparam int IDX_W       = 12;
   localparam int HT_W        = 16;
   localparam int OFS_W       = 26;
   localparam int POS_W       = 11;
   localparam int OP_W        = 2;
   localparam int REQ_DATA_W  = 72;
   localparam int RSP_DATA_W  = 120;

   typedef enum logic [OP_W-1:0] {
      OP_SET   = 2'd0,
      OP_READ  = 2'd1,
      OP_QUERY = 2'd2,
      OP_CLEAR = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_ZERO,
      ST_WRITE,
      ST_RB_RD,
      ST_RB_WR,
      ST_SC_RD,
      ST_SC_EV
   } state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic latch;
      logic zero_init;
      logic zero_step;
      logic set_write;
      logic walk_start;
      logic rd_ptr;
      logic rd_idx;
      logic rb_write;
      logic rb_finish;
      logic scan_eval;
      logic clear;
      logic load_out;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      op_type op;
      logic   idx_oob;
      logic   grow;
      logic   idx_in_range;
      logic   empty;
      logic   zero_done;
      logic   walk_done;
      logic   out_busy;
   } stat_type;

endpackage

@@ src/phtr_ctrl.sv @@
// Sequencer for the prefix height table: dispatches each word and walks the table.
// Depends on phtr_pkg for the state, command and status types.
`timescale 1ns / 1ps
module phtr_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  phtr_pkg::stat_type stat,
   output phtr_pkg::cmd_type  cmd
);
   import phtr_pkg::*;

   state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = !stat.out_busy;
            if (req_tvalid && !stat.out_busy) begin
               cmd.latch = 1'b1;
               state_in  = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            unique case (stat.op)
               OP_SET: begin
                  if (stat.idx_oob) begin
                     cmd.load_out = 1'b1;
                     state_in     = ST_IDLE;
                  end else if (stat.grow) begin
                     cmd.zero_init = 1'b1;
                     state_in      = ST_ZERO;
                  end else begin
                     state_in = ST_WRITE;
                  end
               end
               OP_READ: begin
                  // read data is registered here and goes to the output register from ST_SC_EV
                  cmd.rd_idx = stat.idx_in_range;
                  state_in   = ST_SC_EV;
               end
               OP_QUERY: begin
                  if (stat.empty) begin
                     cmd.load_out = 1'b1;
                     state_in     = ST_IDLE;
                  end else begin
                     cmd.walk_start = 1'b1;
                     state_in       = ST_SC_RD;
                  end
               end
               OP_CLEAR: begin
                  cmd.clear    = 1'b1;
                  cmd.load_out = 1'b1;
                  state_in     = ST_IDLE;
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_ZERO: begin
            if (stat.zero_done) begin
               state_in = ST_WRITE;
            end else begin
               cmd.zero_step = 1'b1;
            end
         end
         ST_WRITE: begin
            cmd.set_write  = 1'b1;
            cmd.walk_start = 1'b1;
            state_in       = ST_RB_RD;
         end
         ST_RB_RD: begin
            if (stat.walk_done) begin
               cmd.rb_finish = 1'b1;
               cmd.load_out  = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               cmd.rd_ptr = 1'b1;
               state_in   = ST_RB_WR;
            end
         end
         ST_RB_WR: begin
            cmd.rb_write = 1'b1;
            state_in     = ST_RB_RD;
         end
         ST_SC_RD: begin
            if (stat.walk_done) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               cmd.rd_ptr = 1'b1;
               state_in   = ST_SC_EV;
            end
         end
         ST_SC_EV: begin
            // a read entry finishes here; a scan evaluates and goes on
            if (stat.op == OP_READ) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               cmd.scan_eval = 1'b1;
               state_in      = ST_SC_RD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

@@ src/phtr_dp.sv @@
// Datapath: height and offset memories, walk pointer, prefix accumulator,
// window compares and the result register. Depends on phtr_pkg.
`timescale 1ns / 1ps
module phtr_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  phtr_pkg::cmd_type                   cmd,
   output phtr_pkg::stat_type                  stat,
   input  logic [phtr_pkg::OP_W-1:0]           req_op,
   input  logic [phtr_pkg::REQ_DATA_W-1:0]     req_data,
   input  logic [phtr_pkg::HT_W-1:0]           render_padding,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [phtr_pkg::RSP_DATA_W-1:0]     rsp_tdata
);
   import phtr_pkg::*;

   localparam int BOT_W  = OFS_W + 2;
   localparam int HPAD_W = OFS_W - HEIGHT_BITS;

   logic [HEIGHT_BITS-1:0] height_mem [MAX_ENTRIES];
   logic [OFS_W-1:0]       offset_mem [MAX_ENTRIES];

   op_type                 op_ff;
   logic [IDX_W-1:0]       idx_ff;
   logic [HEIGHT_BITS-1:0] ht_ff;
   logic [OFS_W-1:0]       top_ff;
   logic [HT_W-1:0]        view_ff;

   logic [CNT_W-1:0]       count_ff;
   logic [CNT_W-1:0]       ptr_ff;
   logic [OFS_W-1:0]       acc_ff;
   logic [OFS_W-1:0]       total_ff;
   logic [HEIGHT_BITS-1:0] hrd_ff;
   logic [OFS_W-1:0]       ord_ff;
   logic [CNT_W-1:0]       rd_idx_ff;

   logic                   ffound_ff, rfound_ff;
   logic [POS_W-1:0]       fv_ff, lv_ff, rf_ff, rl_ff;

   logic                   rsp_valid_ff;
   logic [RSP_DATA_W-1:0]  rsp_data_ff;
   logic [RSP_DATA_W-1:0]  rsp_data_in;

   logic [ADDR_W-1:0]      rd_addr;
   logic [ADDR_W-1:0]      hwr_addr;
   logic [HEIGHT_BITS-1:0] hwr_data;
   logic [OFS_W:0]         end_pos;
   logic [BOT_W-1:0]       bottom;
   logic [BOT_W-1:0]       rbottom;
   logic [OFS_W-1:0]       rtop;
   logic [OFS_W-1:0]       hrd_ext;
   logic [POS_W-1:0]       cur_pos;
   logic                   in_range_ff;

   // Latch the request word
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         op_ff   <= op_type'(req_op);
         idx_ff  <= req_data[IDX_W-1:0];
         ht_ff   <= req_data[IDX_W +: HEIGHT_BITS];
         top_ff  <= req_data[IDX_W+HT_W +: OFS_W];
         view_ff <= req_data[IDX_W+HT_W+OFS_W +: HT_W];
      end
   end

   // Status back to the controller
   always_comb begin
      stat.op           = op_ff;
      stat.idx_oob      = idx_ff >= IDX_W'(MAX_ENTRIES);
      stat.grow         = idx_ff >= IDX_W'(count_ff);
      stat.idx_in_range = idx_ff < IDX_W'(count_ff);
      stat.empty        = count_ff == '0;
      stat.zero_done    = IDX_W'(ptr_ff) >= idx_ff;
      stat.walk_done    = ptr_ff == count_ff;
      stat.out_busy     = rsp_valid_ff;
   end

   // Memory ports
   assign rd_addr  = cmd.rd_idx ? idx_ff[ADDR_W-1:0] : ptr_ff[ADDR_W-1:0];
   assign hwr_addr = cmd.set_write ? idx_ff[ADDR_W-1:0] : ptr_ff[ADDR_W-1:0];
   assign hwr_data = cmd.set_write ? ht_ff : '0;

   always_ff @(posedge clock) begin
      if (cmd.set_write || cmd.zero_step) begin
         height_mem[hwr_addr] <= hwr_data;
      end
      if (cmd.rb_write) begin
         offset_mem[ptr_ff[ADDR_W-1:0]] <= acc_ff;
      end
      if (cmd.rd_ptr || cmd.rd_idx) begin
         hrd_ff    <= height_mem[rd_addr];
         ord_ff    <= offset_mem[rd_addr];
      end
      if (cmd.rd_ptr) begin
         rd_idx_ff <= ptr_ff;
      end
      if (cmd.latch) begin
         in_range_ff <= 1'b0;
      end else if (cmd.rd_idx) begin
         in_range_ff <= 1'b1;
      end
   end

   // Entry count, walk pointer, accumulator, total
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         total_ff <= '0;
      end else begin
         if (cmd.clear) begin
            count_ff <= '0;
            total_ff <= '0;
         end else if (cmd.set_write && stat.grow) begin
            count_ff <= CNT_W'(idx_ff) + CNT_W'(1);
         end
         if (cmd.rb_finish) begin
            total_ff <= acc_ff;
         end
      end
   end

   assign hrd_ext = {{HPAD_W{1'b0}}, hrd_ff};

   always_ff @(posedge clock) begin
      if (cmd.zero_init) begin
         ptr_ff <= count_ff;
      end else if (cmd.walk_start) begin
         ptr_ff <= '0;
      end else if (cmd.zero_step || cmd.rb_write || cmd.scan_eval) begin
         ptr_ff <= ptr_ff + CNT_W'(1);
      end
      if (cmd.walk_start) begin
         acc_ff <= '0;
      end else if (cmd.rb_write) begin
         acc_ff <= acc_ff + hrd_ext;
      end
   end

   // Window bounds
   assign bottom  = BOT_W'(top_ff) + BOT_W'(view_ff);
   assign rbottom = bottom + BOT_W'(render_padding);
   assign rtop    = (top_ff >= OFS_W'(render_padding)) ? top_ff - OFS_W'(render_padding) : '0;
   assign end_pos = {1'b0, ord_ff} + {1'b0, hrd_ext};
   assign cur_pos = POS_W'(rd_idx_ff);

   // Scan: first entry ending below the top, last entry starting above the bottom
   always_ff @(posedge clock) begin
      if (cmd.walk_start) begin
         ffound_ff <= 1'b0;
         rfound_ff <= 1'b0;
         fv_ff     <= POS_W'(count_ff) - POS_W'(1);
         rf_ff     <= POS_W'(count_ff) - POS_W'(1);
         lv_ff     <= '0;
         rl_ff     <= '0;
      end else if (cmd.scan_eval) begin
         if (!ffound_ff && end_pos > {1'b0, top_ff}) begin
            ffound_ff <= 1'b1;
            fv_ff     <= cur_pos;
         end
         if (!rfound_ff && end_pos > {1'b0, rtop}) begin
            rfound_ff <= 1'b1;
            rf_ff     <= cur_pos;
         end
         if (BOT_W'(ord_ff) < bottom) begin
            lv_ff <= cur_pos;
         end
         if (BOT_W'(ord_ff) < rbottom) begin
            rl_ff <= cur_pos;
         end
      end
   end

   // Result register; fields from the lowest bit up
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Assemble the response word
   always_comb begin
      rsp_data_in = '0;
      unique case (op_ff)
         OP_SET: begin
            rsp_data_in[113] = stat.idx_oob;
         end
         OP_READ: begin
            if (in_range_ff) begin
               rsp_data_in[59:44] = HT_W'(hrd_ff);
               rsp_data_in[85:60] = ord_ff;
               rsp_data_in[86]    = hrd_ff != '0;
            end
         end
         OP_QUERY: begin
            if (stat.empty) begin
               rsp_data_in[21:11] = '1;
               rsp_data_in[43:33] = '1;
            end else begin
               rsp_data_in[10:0]  = fv_ff;
               rsp_data_in[21:11] = lv_ff;
               rsp_data_in[32:22] = rf_ff;
               rsp_data_in[43:33] = rl_ff;
            end
         end
         OP_CLEAR: begin
         end
         default: begin
         end
      endcase
      // total as it stands after this word
      rsp_data_in[112:87] = (cmd.clear || stat.empty) ? '0 :
                            (cmd.rb_finish ? acc_ff : total_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

@@ src/prefix_height_table_range_finder_unit.sv @@
// One word at a time: a new word is taken only when the unit is idle and the
// result register is empty. Set and range query words walk the table through a
// single memory read port, reading each entry and then writing back its offset
// (set) or evaluating it (query); the walk sets the rate. An empty table query
// skips the walk. Reset: synchronous, clears entry count, total, padding and
// handshake state; entries are zero filled as the count grows.
`timescale 1ns / 1ps
module prefix_height_table_range_finder_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // tdata: item_index[11:0], item_height[27:12], scroll_offset[53:28],
   //        viewport_height[69:54], zero fill
   input  logic [phtr_pkg::REQ_DATA_W-1:0]     req_tdata,
   // tuser: operation[1:0]
   input  logic [phtr_pkg::OP_W-1:0]           req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // tdata: first_visible[10:0], last_visible[21:11], render_first[32:22],
   //        render_last[43:33], entry_height[59:44], entry_offset[85:60],
   //        entry_present[86], total_height[112:87], index_error[113], zero fill
   output logic [phtr_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [2:0]                          csr_paddr,
   input  logic [31:0]                         csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                csr_pready
);
   import phtr_pkg::*;

   localparam logic CSR_PADDING = 1'b0;

   logic [HT_W-1:0] padding_ff;
   cmd_type         cmd;
   stat_type        stat;

   // Configuration register
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         padding_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr[2] == CSR_PADDING) begin
         padding_ff <= csr_pwdata[HT_W-1:0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == CSR_PADDING) ? 32'(padding_ff) : '0;

   phtr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   phtr_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_op         (req_tuser),
      .req_data       (req_tdata),
      .render_padding (padding_ff),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata)
   );

endmodule

@@ verif/tb_prefix_height_table_range_finder_unit.sv @@
// Testbench for the prefix height table range finder: drives set, read, range
// query and clear words and checks every response against a behavioral table.
// Depends on phtr_pkg and prefix_height_table_range_finder_unit.
`timescale 1ns / 1ps
module tb_prefix_height_table_range_finder_unit;
   import phtr_pkg::*;

   localparam int CAP = MAX_ENTRIES;

   typedef struct packed {
      logic [POS_W-1:0] first_visible;
      logic [POS_W-1:0] last_visible;
      logic [POS_W-1:0] render_first;
      logic [POS_W-1:0] render_last;
      logic [HT_W-1:0]  entry_height;
      logic [OFS_W-1:0] entry_offset;
      logic             entry_present;
      logic [OFS_W-1:0] total_height;
      logic             index_error;
   } answer_type;

   typedef struct {
      op_type           op;
      logic [IDX_W-1:0] idx;
      logic [HT_W-1:0]  ht;
      logic [OFS_W-1:0] scroll;
      logic [HT_W-1:0]  view;
      logic             has_answer;
      answer_type       answer;
   } row_type;

   logic clock, reset;
   logic req_tvalid, req_tready, rsp_tvalid, rsp_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [OP_W-1:0]       req_tuser;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;

   // table model state
   logic [HT_W-1:0]  heights [CAP];
   logic [OFS_W-1:0] offsets [CAP];
   int unsigned      used_count;
   logic [HT_W-1:0]  padding;

   answer_type pending_answers [$];
   int      errors;
   int      send_idle_pct, recv_idle_pct;
   bit      hold_rsp;
   row_type directed [$];

   prefix_height_table_range_finder_unit u_top (.*);

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   initial begin
      #200ms;
      $display("Regression FAIL");
      $finish;
   end

   // rebuild prefix offsets from heights
   function automatic void rebuild_offsets();
      logic [OFS_W-1:0] acc;
      acc = '0;
      for (int i = 0; i < used_count; i++) begin
         offsets[i] = acc;
         acc = acc + heights[i];
      end
   endfunction

   function automatic int first_overlap(longint top);
      for (int i = 0; i < used_count; i++)
         if (longint'(offsets[i]) + longint'(heights[i]) > top) return i;
      return int'(used_count) - 1;
   endfunction

   function automatic int last_overlap(longint bottom);
      for (int i = int'(used_count) - 1; i >= 0; i--)
         if (longint'(offsets[i]) < bottom) return i;
      return 0;
   endfunction

   // apply one word to the table model and return its response
   function automatic answer_type predict_word(row_type r);
      answer_type a;
      longint top, bottom, rtop;
      a = '0;
      case (r.op)
         OP_SET: begin
            if (r.idx >= CAP) a.index_error = 1'b1;
            else begin
               if (r.idx >= used_count) used_count = r.idx + 1;
               heights[r.idx[ADDR_W-1:0]] = r.ht;
            end
         end
         OP_READ: begin
            rebuild_offsets();
            if (r.idx < used_count) begin
               a.entry_height  = heights[r.idx[ADDR_W-1:0]];
               a.entry_offset  = offsets[r.idx[ADDR_W-1:0]];
               a.entry_present = heights[r.idx[ADDR_W-1:0]] != 0;
            end
         end
         OP_QUERY: begin
            rebuild_offsets();
            if (used_count == 0) begin
               a.last_visible = '1;
               a.render_last  = '1;
            end else begin
               top    = r.scroll;
               bottom = top + r.view;
               rtop   = top - padding;
               if (rtop < 0) rtop = 0;
               a.first_visible = POS_W'(first_overlap(top));
               a.last_visible  = POS_W'(last_overlap(bottom));
               a.render_first  = POS_W'(first_overlap(rtop));
               a.render_last   = POS_W'(last_overlap(bottom + padding));
            end
         end
         default: begin
            for (int i = 0; i < CAP; i++) heights[i] = '0;
            used_count = 0;
         end
      endcase
      rebuild_offsets();
      if (used_count != 0)
         a.total_height = offsets[used_count-1] + heights[used_count-1];
      return a;
   endfunction

   // offer one word; valid stays up until the next word or an idle cycle
   task automatic send_word(row_type r);
      answer_type a;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= r.op;
      req_tdata  <= {2'b0, r.view, r.scroll, r.ht, r.idx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      a = predict_word(r);
      if (r.has_answer && a !== r.answer) begin
         $display("%0t table row mismatch: expected %h actual model %h", $time, r.answer, a);
         errors++;
      end
      pending_answers.push_back(a);
   endtask

   task automatic write_padding(logic [HT_W-1:0] value);
      int guard;
      guard = 0;
      req_tvalid <= 1'b0;
      while (pending_answers.size() != 0 && guard < 100000) begin
         @(posedge clock);
         guard++;
      end
      repeat (2200) @(posedge clock);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_paddr <= '0;
      csr_pwdata <= {16'b0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      padding = value;
   endtask

   function automatic row_type mk(op_type op, int idx, int ht, int scroll, int view);
      row_type r;
      r.op = op; r.idx = IDX_W'(idx); r.ht = HT_W'(ht); r.scroll = OFS_W'(scroll);
      r.view = HT_W'(view);
      r.has_answer = 1'b0; r.answer = '0;
      return r;
   endfunction

   function automatic row_type random_word(int span);
      row_type r;
      int pick;
      pick = $urandom_range(99);
      r = mk(OP_SET, $urandom_range(span), $urandom_range(1, 300), 0, 0);
      if ($urandom_range(9) == 0) r.ht = HT_W'($urandom);
      if (pick < 8) r.idx = IDX_W'($urandom);
      if (pick >= 40 && pick < 62) r.op = OP_READ;
      if (pick >= 62 && pick < 97) begin
         r.op = OP_QUERY;
         r.scroll = OFS_W'($urandom_range(span * 200));
         r.view = HT_W'($urandom_range(900));
         if ($urandom_range(7) == 0) begin
            r.scroll = OFS_W'($urandom); r.view = HT_W'($urandom);
         end
      end
      if (pick >= 97) r.op = OP_CLEAR;
      return r;
   endfunction

   // receiver: random stalls, plus one long hold-off
   always @(posedge clock) begin
      if (reset || hold_rsp) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // compare each response word with the oldest prediction
   always @(posedge clock) begin
      answer_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[10:0], rsp_tdata[21:11], rsp_tdata[32:22], rsp_tdata[43:33],
                rsp_tdata[59:44], rsp_tdata[85:60], rsp_tdata[86], rsp_tdata[112:87],
                rsp_tdata[113]};
         if (pending_answers.size() == 0) begin
            $display("%0t unexpected word: expected none actual %h", $time, got);
            errors++;
         end else begin
            want = pending_answers.pop_front();
            if (got !== want) begin
               $display("%0t word mismatch: expected %h actual %h", $time, want, got);
               errors++;
            end
         end
      end
   end

   initial begin
      answer_type a;
      row_type r;
      int guard;
      errors = 0; send_idle_pct = 0; recv_idle_pct = 0; hold_rsp = 1'b0;
      used_count = 0; padding = '0;
      for (int i = 0; i < CAP; i++) begin heights[i] = '0; offsets[i] = '0; end
      reset = 1'b1; req_tvalid = 1'b0; req_tdata = '0; req_tuser = OP_SET;
      csr_psel = 1'b0; csr_penable = 1'b0; csr_pwrite = 1'b0;
      csr_paddr = '0; csr_pwdata = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table: empty table, extremes, overflow index, clear
      r = mk(OP_QUERY, 0, 0, 0, 0); r.has_answer = 1;
      r.answer = '0; r.answer.last_visible = '1; r.answer.render_last = '1;
      directed.push_back(r);
      r = mk(OP_READ, 4095, 0, 0, 0); r.has_answer = 1; r.answer = '0;
      directed.push_back(r);
      r = mk(OP_SET, 4095, 65535, 0, 0); r.has_answer = 1;
      r.answer = '0; r.answer.index_error = 1; directed.push_back(r);
      r = mk(OP_SET, 1024, 5, 0, 0); r.has_answer = 1;
      r.answer = '0; r.answer.index_error = 1; directed.push_back(r);
      directed.push_back(mk(OP_SET, 0, 65535, 0, 0));
      directed.push_back(mk(OP_SET, 3, 10, 0, 0));
      directed.push_back(mk(OP_READ, 1, 0, 0, 0));
      directed.push_back(mk(OP_READ, 3, 0, 0, 0));
      directed.push_back(mk(OP_QUERY, 0, 0, 65530, 20));
      directed.push_back(mk(OP_QUERY, 0, 0, 67108863, 65535));
      directed.push_back(mk(OP_SET, 1023, 65535, 0, 0));
      directed.push_back(mk(OP_READ, 1023, 0, 0, 0));
      directed.push_back(mk(OP_QUERY, 0, 0, 0, 0));
      directed.push_back(mk(OP_SET, 1023, 65535, 0, 0));
      directed.push_back(mk(OP_SET, 3, 0, 0, 0));
      directed.push_back(mk(OP_READ, 3, 0, 0, 0));
      r = mk(OP_CLEAR, 0, 0, 0, 0); r.has_answer = 1; r.answer = '0;
      directed.push_back(r);
      r = mk(OP_READ, 0, 0, 0, 0); r.has_answer = 1; r.answer = '0;
      directed.push_back(r);
      foreach (directed[i]) send_word(directed[i]);

      // random phases across padding settings and idle mixes
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin write_padding(16'hFFFF); send_idle_pct = 23; recv_idle_pct = 48; end
            1: begin write_padding(16'd0);    send_idle_pct = 48; recv_idle_pct = 23; end
            2: begin write_padding(HT_W'($urandom_range(1, 500))); send_idle_pct = 0;
                     recv_idle_pct = 0; end
            default: begin write_padding(HT_W'($urandom)); end
         endcase
         if (phase == 2) begin
            hold_rsp = 1'b1;
            fork
               begin repeat (300) @(posedge clock); hold_rsp = 1'b0; end
            join_none
         end
         for (int k = 0; k < 68; k++)
            send_word(random_word(phase == 3 ? 1023 : 40));
      end

      req_tvalid <= 1'b0;
      guard = 0;
      while (pending_answers.size() != 0 && guard < 500000) begin
         @(posedge clock);
         guard++;
      end
      repeat (2200) @(posedge clock);
      if (errors == 0 && pending_answers.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
